@@ sv/dqfb_pkg.sv @@
// ----------------------------------------------------------------------------
// dqfb_pkg - shared types and constants of the DNS query frame builder
// Command word passed from the front to the back, back state codes,
// header byte table and configuration register indexes.
// ----------------------------------------------------------------------------
package dqfb_pkg;

    localparam logic [7:0]  DOT_CHAR   = 8'd46;
    localparam logic [15:0] SOA_TYPE   = 16'd6;
    localparam int          HDR_BYTES  = 12;
    localparam int          FIN_BYTES  = 5;
    localparam int          CMDQ_DEPTH = 4;

    // header byte positions that may be non-zero
    localparam logic [3:0]  HDR_FLAGS_IDX   = 4'd2;
    localparam logic [3:0]  HDR_QDCOUNT_IDX = 4'd5;

    // configuration register indexes
    localparam logic CFG_QUERY_TYPE  = 1'b0;
    localparam logic CFG_QUERY_CLASS = 1'b1;

    // label index and length fields sized for the largest allowed label
    typedef struct packed {
        logic       hdr;     // send the 12-byte header first
        logic       store;   // write ch into the label store at addr
        logic       close;   // emit length byte and len stored bytes
        logic       finish;  // emit terminator (and type/class) and end frame
        logic       err;     // frame was cut short
        logic [7:0] ch;
        logic [7:0] addr;
        logic [7:0] len;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HDR,
        B_LEN,
        B_BODY,
        B_FIN
    } t_back_state;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic rd);
        logic [7:0] b;
        case (idx)
            HDR_FLAGS_IDX:   b = {7'd0, rd};
            HDR_QDCOUNT_IDX: b = 8'd1;
            default:         b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

@@ sv/dqfb_front.sv @@
// ----------------------------------------------------------------------------
// dqfb_front - character classifier
// Accepts one name character per cycle while the command queue has room,
// tracks label/name length and error state; one back command per character.
// ----------------------------------------------------------------------------
module dqfb_front #(
    parameter int MAX_NAME  = 255,
    parameter int MAX_LABEL = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output dqfb_pkg::t_cmd o_cmd
);

    localparam int NLW = $clog2(MAX_NAME + 1);
    localparam int LLW = $clog2(MAX_LABEL + 1);

    logic           r_in_frame, n_in_frame;
    logic           r_err, n_err;
    logic [NLW-1:0] r_nl, n_nl;
    logic [LLW-1:0] r_ll, n_ll;
    logic           w_acc;
    dqfb_pkg::t_cmd w_cmd;

    assign w_acc   = i_valid && !i_full;
    assign o_ready = !i_full;
    assign o_push  = w_acc;
    assign o_cmd   = w_cmd;

    always_comb begin
        w_cmd      = '0;
        w_cmd.hdr  = !r_in_frame;
        w_cmd.ch   = i_char;
        w_cmd.addr = 8'(r_ll);
        n_err      = r_err;
        n_nl       = r_nl;
        n_ll       = r_ll;
        n_in_frame = 1'b1;
        if (!r_err) begin
            if (r_nl >= NLW'(MAX_NAME)) begin
                n_err = 1'b1;
            end else begin
                n_nl = r_nl + NLW'(1);
                if (i_char == dqfb_pkg::DOT_CHAR) begin
                    w_cmd.close = 1'b1;
                    w_cmd.len   = 8'(r_ll);
                    n_ll        = '0;
                end else if (r_ll >= LLW'(MAX_LABEL)) begin
                    // label too long: drop it
                    n_err = 1'b1;
                    n_ll  = '0;
                end else begin
                    w_cmd.store = 1'b1;
                    n_ll        = r_ll + LLW'(1);
                    if (i_last) begin
                        w_cmd.close = 1'b1;
                        w_cmd.len   = 8'(r_ll) + 8'd1;
                    end
                end
            end
        end
        if (i_last) begin
            w_cmd.finish = 1'b1;
            w_cmd.err    = n_err;
            n_err        = 1'b0;
            n_nl         = '0;
            n_ll         = '0;
            n_in_frame   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_err      <= 1'b0;
            r_nl       <= '0;
            r_ll       <= '0;
        end else if (w_acc) begin
            r_in_frame <= n_in_frame;
            r_err      <= n_err;
            r_nl       <= n_nl;
            r_ll       <= n_ll;
        end
    end

endmodule

@@ sv/dqfb_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// dqfb_cmd_fifo - command queue between front and back
// Small register FIFO; head entry is shown while not empty.
// ----------------------------------------------------------------------------
module dqfb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dqfb_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output dqfb_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = $clog2(dqfb_pkg::CMDQ_DEPTH);
    localparam int CW = $clog2(dqfb_pkg::CMDQ_DEPTH + 1);

    dqfb_pkg::t_cmd r_mem [dqfb_pkg::CMDQ_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_cmd   = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(dqfb_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

@@ sv/dqfb_back.sv @@
// ----------------------------------------------------------------------------
// dqfb_back - frame byte sequencer and word packer
// Executes commands: header, label store write, label emission from the
// label store, frame finish. Bytes are packed eight to a word, first byte
// in the top lane, into an output register.
// ----------------------------------------------------------------------------
module dqfb_back #(
    parameter int MAX_LABEL = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dqfb_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  logic [15:0]    i_query_type,
    input  logic [15:0]    i_query_class,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [63:0]    o_frame_word,
    output logic [3:0]     o_byte_count,
    output logic           o_frame_end,
    output logic           o_frame_error
);

    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    logic [7:0]            r_mem [MAX_LABEL];
    logic [7:0]            r_rd_data;
    dqfb_pkg::t_back_state r_state, n_state;
    dqfb_pkg::t_cmd        r_cmd;
    logic [7:0]            r_idx, n_idx;
    logic [63:0]           r_pack, w_pack;
    logic [2:0]            r_pcnt;
    logic                  r_ovalid;
    logic [63:0]           r_oword;
    logic [3:0]            r_ocnt;
    logic                  r_oend;
    logic                  r_oerr;

    logic                  w_pop;
    logic [7:0]            w_byte;
    logic                  w_byte_valid;
    logic                  w_byte_last;
    logic                  w_ph_end;
    logic                  w_emit;
    logic                  w_adv;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    dqfb_pkg::t_back_state w_first;
    dqfb_pkg::t_back_state w_after_close;
    dqfb_pkg::t_back_state w_after_hdr;

    assign w_pop        = (r_state == dqfb_pkg::B_IDLE) && !i_cmd_empty;
    assign o_cmd_pop    = w_pop;
    assign w_byte_valid = (r_state != dqfb_pkg::B_IDLE);

    assign w_after_close = r_cmd.finish ? dqfb_pkg::B_FIN : dqfb_pkg::B_IDLE;
    assign w_after_hdr   = r_cmd.close ? dqfb_pkg::B_LEN : w_after_close;
    assign w_first = i_cmd.hdr    ? dqfb_pkg::B_HDR :
                     i_cmd.close  ? dqfb_pkg::B_LEN :
                     i_cmd.finish ? dqfb_pkg::B_FIN : dqfb_pkg::B_IDLE;

    // byte source for the current phase
    always_comb begin
        w_byte      = 8'd0;
        w_ph_end    = 1'b0;
        w_byte_last = 1'b0;
        case (r_state)
            dqfb_pkg::B_HDR: begin
                w_byte   = dqfb_pkg::hdr_byte(r_idx[3:0],
                                              i_query_type == dqfb_pkg::SOA_TYPE);
                w_ph_end = (r_idx == 8'(dqfb_pkg::HDR_BYTES - 1));
            end
            dqfb_pkg::B_LEN: begin
                w_byte   = r_cmd.len;
                w_ph_end = 1'b1;
            end
            dqfb_pkg::B_BODY: begin
                w_byte   = r_rd_data;
                w_ph_end = (r_idx == r_cmd.len - 8'd1);
            end
            dqfb_pkg::B_FIN: begin
                case (r_idx[2:0])
                    3'd1:    w_byte = i_query_type[15:8];
                    3'd2:    w_byte = i_query_type[7:0];
                    3'd3:    w_byte = i_query_class[15:8];
                    3'd4:    w_byte = i_query_class[7:0];
                    default: w_byte = 8'd0;
                endcase
                // on error only the terminator goes out
                w_ph_end    = r_cmd.err || (r_idx == 8'(dqfb_pkg::FIN_BYTES - 1));
                w_byte_last = w_ph_end;
            end
            default: begin
                w_byte = 8'd0;
            end
        endcase
    end

    assign w_emit = w_byte_valid && ((r_pcnt == 3'd7) || w_byte_last);
    assign w_adv  = w_byte_valid && (!w_emit || !r_ovalid || i_out_ready);

    // next label byte is read ahead into a register
    assign w_rd_en = w_adv &&
                     (((r_state == dqfb_pkg::B_LEN) && (r_cmd.len != 8'd0)) ||
                      ((r_state == dqfb_pkg::B_BODY) && !w_ph_end));
    assign w_rd_addr = (r_state == dqfb_pkg::B_LEN) ? '0 : AW'(r_idx + 8'd1);

    always_comb begin
        w_pack = r_pack;
        for (int k = 0; k < 8; k++) begin
            if (r_pcnt == 3'(k)) begin
                w_pack[63 - 8*k -: 8] = w_byte;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (w_pop) begin
            n_state = w_first;
            n_idx   = 8'd0;
        end else if (w_adv) begin
            if (w_ph_end) begin
                n_idx = 8'd0;
                case (r_state)
                    dqfb_pkg::B_HDR:  n_state = w_after_hdr;
                    dqfb_pkg::B_LEN:  n_state = (r_cmd.len != 8'd0) ? dqfb_pkg::B_BODY
                                                                    : w_after_close;
                    dqfb_pkg::B_BODY: n_state = w_after_close;
                    default:          n_state = dqfb_pkg::B_IDLE;
                endcase
            end else begin
                n_idx = r_idx + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.store) begin
            r_mem[i_cmd.addr[AW-1:0]] <= i_cmd.ch;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqfb_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_adv && w_emit) begin
            r_oword <= w_pack;
            r_ocnt  <= {1'b0, r_pcnt} + 4'd1;
            r_oend  <= w_byte_last;
            r_oerr  <= w_byte_last && r_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack   <= '0;
            r_pcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_adv) begin
                if (w_emit) begin
                    r_pack <= '0;
                    r_pcnt <= '0;
                end else begin
                    r_pack <= w_pack;
                    r_pcnt <= r_pcnt + 3'd1;
                end
            end
            if (w_adv && w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_frame_word  = r_oword;
    assign o_byte_count  = r_ocnt;
    assign o_frame_end   = r_oend;
    assign o_frame_error = r_oerr;

endmodule

@@ sv/dns_query_frame_builder.sv @@
// ----------------------------------------------------------------------------
// dns_query_frame_builder - DNS query frame from a dotted host name
// Stream in one name character per word (tlast on the final character),
// stream out the query frame packed in 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tdata[7:0] = name character, tlast = last character of the name.
//   m_axis: tdata[63:0] = frame bytes (first byte in 63:56), tdata[67:64] =
//     valid byte count, tlast = last word of the frame, tuser = error.
//   Config: i_cfg_we/i_cfg_index/i_cfg_data write query type (0) and class (1)
//     while the block is idle; both reset to 1.
// Throughput: the front accepts one character per cycle while the 4-entry
//   command queue has room. The back pops a command only while it is idle and
//   then produces that command's frame bytes, stopping at a finished word while
//   the previous word is not taken: the header gives 12 bytes, a label its
//   length byte and its stored bytes, the frame end 5 bytes (terminator, type
//   and class; only the terminator on error).
// First word: valid once the back has popped the header command and packed eight header bytes into the output register.
// Reset: synchronous active low; empties the queue and the output register,
//   restores default type and class, starts with a new frame.
// Stall: with m_axis_tready low the finished word is held; the back stops at
//   the next finished word, the queue fills and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module dns_query_frame_builder #(
    parameter int MAX_NAME  = 255,
    parameter int MAX_LABEL = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] name_char
    input  logic        s_axis_tlast,   // name_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] frame_word, [67:64] byte_count, pad
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser    // [0] frame_error
);

    logic [15:0]    r_query_type;
    logic [15:0]    r_query_class;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    dqfb_pkg::t_cmd w_front_cmd;
    dqfb_pkg::t_cmd w_head_cmd;
    logic [63:0]    w_word;
    logic [3:0]     w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_type  <= 16'd1;
            r_query_class <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dqfb_pkg::CFG_QUERY_TYPE:  r_query_type  <= i_cfg_data;
                dqfb_pkg::CFG_QUERY_CLASS: r_query_class <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dqfb_front #(
        .MAX_NAME  (MAX_NAME),
        .MAX_LABEL (MAX_LABEL)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_front_cmd)
    );

    dqfb_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    dqfb_back #(
        .MAX_LABEL (MAX_LABEL)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_cmd_empty   (w_empty),
        .o_cmd_pop     (w_pop),
        .i_query_type  (r_query_type),
        .i_query_class (r_query_class),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_frame_word  (w_word),
        .o_byte_count  (w_count),
        .o_frame_end   (m_axis_tlast),
        .o_frame_error (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, w_count, w_word};

    // only the final word of a frame may be short
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[67:64] == 4'd8)
        else $error("non-final word with fewer than eight bytes");

    // error flag rides only on the frame's last word
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_error on a word that does not end the frame");

    // the back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

endmodule

@@ tb/sv/dns_query_frame_builder_tb.sv @@
// ----------------------------------------------------------------------------
// dns_query_frame_builder_tb - self-checking bench for the DNS query builder
// Streams host names into the block one character per word and checks every
// frame word against a cycle-free model of the header, label encoding,
// type/class trailer and the truncation rules. Both stream sides idle and
// stall at random; the query type and class change between phases.
// ----------------------------------------------------------------------------
module dns_query_frame_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_LIMIT  = 255;
    localparam int LABEL_LIMIT = 63;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_name_char;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        fend;
        logic        ferr;
    } t_frame_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = dqfb_pkg::CFG_QUERY_TYPE;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    dns_query_frame_builder #(
        .MAX_NAME  (NAME_LIMIT),
        .MAX_LABEL (LABEL_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    t_name_char  name_chars[$];
    t_frame_word expected_words[$];
    t_frame_word step_words[$];
    int          queued_items = 0;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;

    // builder model state
    logic [15:0] cur_type = 16'd1;
    logic [15:0] cur_class = 16'd1;
    logic [7:0]  label_bytes [0:LABEL_LIMIT-1];
    int          label_len = 0;
    int          name_len = 0;
    bit          frame_open = 1'b0;
    logic [63:0] pack_bytes = '0;
    int          pack_cnt = 0;
    bit          truncated = 1'b0;

    function automatic void put_byte(input logic [7:0] b);
        pack_bytes = {pack_bytes[55:0], b};
        pack_cnt++;
        if (pack_cnt == 8) begin
            step_words.push_back('{pack_bytes, 4'd8, 1'b0, 1'b0});
            pack_bytes = '0;
            pack_cnt = 0;
        end
    endfunction

    function automatic void emit_label();
        put_byte(label_len[7:0]);
        for (int i = 0; i < label_len; i++)
            put_byte(label_bytes[i]);
        label_len = 0;
    endfunction

    function automatic void end_frame();
        t_frame_word tail;
        bit          cut;
        cut = truncated;
        put_byte(8'd0);
        if (!cut) begin
            put_byte(cur_type[15:8]);
            put_byte(cur_type[7:0]);
            put_byte(cur_class[15:8]);
            put_byte(cur_class[7:0]);
        end
        if (pack_cnt > 0) begin
            step_words.push_back('{pack_bytes << (8 * (8 - pack_cnt)), pack_cnt[3:0], 1'b1, cut});
        end else begin
            // frame ended exactly on a word boundary: flag the word just packed
            tail = step_words.pop_back();
            tail.fend = 1'b1;
            tail.ferr = cut;
            step_words.push_back(tail);
        end
        label_len = 0;
        name_len = 0;
        frame_open = 1'b0;
        pack_bytes = '0;
        pack_cnt = 0;
        truncated = 1'b0;
    endfunction

    function automatic void predict_frame_words(input logic [7:0] ch, input logic last);
        step_words.delete();
        if (!frame_open) begin
            for (int i = 0; i < dqfb_pkg::HDR_BYTES; i++) begin
                if (4'(i) == dqfb_pkg::HDR_FLAGS_IDX)
                    put_byte({7'd0, cur_type == dqfb_pkg::SOA_TYPE});
                else if (4'(i) == dqfb_pkg::HDR_QDCOUNT_IDX)
                    put_byte(8'd1);
                else
                    put_byte(8'd0);
            end
            frame_open = 1'b1;
        end
        if (!truncated) begin
            if (name_len >= NAME_LIMIT) begin
                truncated = 1'b1;
            end else begin
                name_len++;
                if (ch == dqfb_pkg::DOT_CHAR) begin
                    emit_label();
                end else if (label_len >= LABEL_LIMIT) begin
                    truncated = 1'b1;
                    label_len = 0;
                end else begin
                    label_bytes[label_len] = ch;
                    label_len++;
                    if (last)
                        emit_label();
                end
            end
        end
        if (last)
            end_frame();
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void add_char(input logic [7:0] ch, input logic last);
        name_chars.push_back('{ch, last});
        queued_items++;
    endfunction

    function automatic void mark_name_end();
        t_name_char c;
        c = name_chars.pop_back();
        c.last = 1'b1;
        name_chars.push_back(c);
    endfunction

    function automatic logic [7:0] label_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == dqfb_pkg::DOT_CHAR)
            ch = ch + 8'd1;
        return ch;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endfunction

    // n characters, a dot after every span label characters, last on the final one
    function automatic void add_run(input int n, input int span);
        for (int i = 0; i < n; i++)
            add_char((i % (span + 1) == span) ? dqfb_pkg::DOT_CHAR : label_char(), i == n - 1);
    endfunction

    function automatic void add_random_name();
        int kind;
        int nlab;
        int len;
        kind = $urandom_range(0, 19);
        if (kind < 15) begin
            nlab = $urandom_range(1, 4);
            for (int j = 0; j < nlab; j++) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    add_char(label_char(), 1'b0);
                if (j < nlab - 1)
                    add_char(dqfb_pkg::DOT_CHAR, 1'b0);
            end
            if ($urandom_range(0, 3) == 0)
                add_char(dqfb_pkg::DOT_CHAR, 1'b0);
        end else if (kind < 18) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
                add_char(($urandom_range(0, 3) == 0) ? dqfb_pkg::DOT_CHAR
                                                     : 8'($urandom_range(0, 255)),
                         1'b0);
        end else if (kind == 18) begin
            add_char(dqfb_pkg::DOT_CHAR, 1'b0);
            add_char(dqfb_pkg::DOT_CHAR, 1'b0);
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                add_char(label_char(), 1'b0);
        end else begin
            // label around the length limit
            len = $urandom_range(LABEL_LIMIT - 3, LABEL_LIMIT + 3);
            for (int k = 0; k < len; k++)
                add_char(label_char(), 1'b0);
        end
        mark_name_end();
    endfunction

    task automatic wait_drained();
        while (name_chars.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == dqfb_pkg::CFG_QUERY_TYPE)
            cur_type = val;
        else
            cur_class = val;
    endtask

    task automatic add_random_names(input int count);
        int start;
        start = queued_items;
        while (queued_items - start < count)
            add_random_name();
    endtask

    // ---------------- name character driver ----------------
    always @(posedge i_clk) begin : drive_chars
        t_name_char c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_frame_words(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (name_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    c = name_chars.pop_front();
                    s_axis_tdata <= c.ch;
                    s_axis_tlast <= c.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- frame word receiver ----------------
    always @(posedge i_clk) begin : accept_words
        static int hold_left = 0;
        static int hold_served = 0;
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_words
        t_frame_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected frame word %h", m_axis_tdata[63:0]);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[63:0] !== want.word) begin
                    $error("frame_word: expected %h, got %h", want.word, m_axis_tdata[63:0]);
                    fail_count++;
                end
                if (m_axis_tdata[67:64] !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, m_axis_tdata[67:64]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.fend) begin
                    $error("frame_end: expected %b, got %b", want.fend, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser !== want.ferr) begin
                    $error("frame_error: expected %b, got %b", want.ferr, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed names, reset type and class
        send_idle_pct = 11;
        recv_idle_pct = 48;
        add_text("a");
        add_text("ab.");
        add_text(".x");
        add_text("a..b");
        add_text(".");
        add_char(8'h00, 1'b0);
        add_char(8'hff, 1'b0);
        add_char(dqfb_pkg::DOT_CHAR, 1'b0);
        add_char(8'h80, 1'b0);
        add_char(8'h7f, 1'b1);
        wait_drained();

        // label length limit, RD bit set, receiver held off to back up the input
        write_reg(dqfb_pkg::CFG_QUERY_TYPE, dqfb_pkg::SOA_TYPE);
        write_reg(dqfb_pkg::CFG_QUERY_CLASS, 16'h0000);
        add_run(LABEL_LIMIT, 1000);
        add_run(LABEL_LIMIT + 1, 1000);
        hold_requests++;
        wait_drained();

        // random names; the sender stops halfway until the output has caught up
        write_reg(dqfb_pkg::CFG_QUERY_TYPE, 16'hffff);
        write_reg(dqfb_pkg::CFG_QUERY_CLASS, 16'hffff);
        add_random_names(15);
        wait_drained();
        add_random_names(15);
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 11;
        write_reg(dqfb_pkg::CFG_QUERY_TYPE, 16'($urandom_range(0, 65535)));
        write_reg(dqfb_pkg::CFG_QUERY_CLASS, 16'($urandom_range(0, 65535)));
        add_random_names(25);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(dqfb_pkg::CFG_QUERY_TYPE, dqfb_pkg::SOA_TYPE);
        write_reg(dqfb_pkg::CFG_QUERY_CLASS, 16'($urandom_range(0, 65535)));
        add_random_names(25);
        wait_drained();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
